// ===== sv/tgm_pkg.sv =====
// Shared types, register indexes and constants of the touchpad gesture to mouse core.
package tgm_pkg;

    // Field widths.
    localparam int COORD_BITS     = 12;
    localparam int ANCHOR_BITS    = COORD_BITS + 2;
    localparam int CURSOR_BITS    = 16;
    localparam int TIME_BITS      = 32;
    localparam int TIMEOUT_BITS   = 16;
    localparam int SCROLL_BITS    = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Depth of the queue between the front and back ends.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOUND_LEFT   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOUND_TOP    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOUND_RIGHT  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOUND_BOTTOM = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_TIMEOUT = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_LIMIT    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WHEEL_STEP   = 3'd6;

    // Configuration reset values.
    localparam logic [COORD_BITS-1:0]   RST_BOUND_LEFT   = '0;
    localparam logic [COORD_BITS-1:0]   RST_BOUND_TOP    = '0;
    localparam logic [COORD_BITS-1:0]   RST_BOUND_RIGHT  = '1;
    localparam logic [COORD_BITS-1:0]   RST_BOUND_BOTTOM = '1;
    localparam logic [TIMEOUT_BITS-1:0] RST_HOLD_TIMEOUT = 16'd700;
    localparam logic [COORD_BITS-1:0]   RST_TAP_LIMIT    = 12'd25;
    localparam logic [COORD_BITS-1:0]   RST_WHEEL_STEP   = 12'd38;

    // Scroll event codes.
    localparam logic [SCROLL_BITS-1:0] SCROLL_NONE  = 3'd0;
    localparam logic [SCROLL_BITS-1:0] SCROLL_UP    = 3'd1;
    localparam logic [SCROLL_BITS-1:0] SCROLL_DOWN  = 3'd2;
    localparam logic [SCROLL_BITS-1:0] SCROLL_RIGHT = 3'd3;
    localparam logic [SCROLL_BITS-1:0] SCROLL_LEFT  = 3'd4;

    // Report slots of one sample, in the order they are sent.
    localparam int SLOT_TAP    = 0;
    localparam int SLOT_RIGHT  = 1;
    localparam int SLOT_HWHEEL = 2;
    localparam int SLOT_VWHEEL = 3;
    localparam int SLOT_FINAL  = 4;
    localparam int SLOT_COUNT  = 5;

    // One touch sample.
    typedef struct packed {
        logic                  primary_down;
        logic [COORD_BITS-1:0] primary_x;
        logic [COORD_BITS-1:0] primary_y;
        logic                  second_down;
        logic                  third_down;
        logic [TIME_BITS-1:0]  now_ms;
    } tgm_in_t;

    // One mouse report.
    typedef struct packed {
        logic signed [CURSOR_BITS-1:0] cursor_x;
        logic signed [CURSOR_BITS-1:0] cursor_y;
        logic                          left_button;
        logic                          right_button;
        logic                          middle_button;
        logic [SCROLL_BITS-1:0]        scroll_event;
        logic                          last_report;
    } tgm_out_t;

    // Configuration register set.
    typedef struct packed {
        logic [COORD_BITS-1:0]   bound_left;
        logic [COORD_BITS-1:0]   bound_top;
        logic [COORD_BITS-1:0]   bound_right;
        logic [COORD_BITS-1:0]   bound_bottom;
        logic [TIMEOUT_BITS-1:0] hold_timeout_ms;
        logic [COORD_BITS-1:0]   tap_move_limit;
        logic [COORD_BITS-1:0]   wheel_step;
    } tgm_cfg_t;

    // Classified sample: everything the back end needs to send its reports.
    typedef struct packed {
        logic signed [CURSOR_BITS-1:0] cursor_x;
        logic signed [CURSOR_BITS-1:0] cursor_y;
        logic                          tap;
        logic                          tap_mid;
        logic                          rclick;
        logic                          rclick_mid;
        logic [SCROLL_BITS-1:0]        hscroll;
        logic [SCROLL_BITS-1:0]        vscroll;
        logic                          wheel_left;
        logic                          wheel_mid;
        logic                          final_left;
        logic                          final_mid;
    } tgm_cmd_t;

endpackage

// ===== sv/tgm_front.sv =====
// Front end: gesture state and classification of each accepted touch sample.
module tgm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  tgm_pkg::tgm_cfg_t cfg,
    input  tgm_pkg::tgm_in_t  sample,
    input  logic              accept,
    output tgm_pkg::tgm_cmd_t cmd
);

    localparam int CB = tgm_pkg::COORD_BITS;
    localparam int AB = tgm_pkg::ANCHOR_BITS;
    localparam int KB = tgm_pkg::CURSOR_BITS;
    localparam int TB = tgm_pkg::TIME_BITS;

    // Gesture state.
    logic                 prev_down_reg, prev_down_next;
    logic [CB-1:0]        prev_x_reg, prev_x_next;
    logic [CB-1:0]        prev_y_reg, prev_y_next;
    logic                 prev_second_reg, prev_second_next;
    logic                 supp_tap_reg, supp_tap_next;
    logic                 supp_right_reg, supp_right_next;
    logic signed [AB-1:0] anchor_x_reg, anchor_x_next;
    logic signed [AB-1:0] anchor_y_reg, anchor_y_next;
    logic [TB-1:0]        press_start_reg, press_start_next;
    logic                 left_held_reg, left_held_next;
    logic                 middle_held_reg, middle_held_next;
    logic [KB-1:0]        cursor_x_reg, cursor_x_next;
    logic [KB-1:0]        cursor_y_reg, cursor_y_next;

    // Next state and command for the current sample.
    always_comb
    begin
        logic                 in_bounds;
        logic                 release_tap;
        logic signed [AB-1:0] xs;
        logic signed [AB-1:0] ys;
        logic signed [AB-1:0] ax;
        logic signed [AB-1:0] ay;
        logic signed [AB-1:0] step_s;
        logic signed [AB-1:0] lim_s;
        logic [TB-1:0]        press_eff;
        logic [TB-1:0]        elapsed;
        logic                 moved;
        logic                 wheel;

        xs        = signed'({2'b00, sample.primary_x});
        ys        = signed'({2'b00, sample.primary_y});
        step_s    = signed'({2'b00, cfg.wheel_step});
        lim_s     = signed'({2'b00, cfg.tap_move_limit});
        ax        = prev_down_reg ? anchor_x_reg : xs;
        ay        = prev_down_reg ? anchor_y_reg : ys;
        press_eff = prev_down_reg ? press_start_reg : sample.now_ms;
        elapsed   = sample.now_ms - press_eff;
        moved     = 1'b0;
        wheel     = 1'b0;

        prev_down_next   = sample.primary_down;
        prev_x_next      = sample.primary_x;
        prev_y_next      = sample.primary_y;
        prev_second_next = sample.second_down;
        supp_tap_next    = supp_tap_reg;
        supp_right_next  = supp_right_reg;
        anchor_x_next    = anchor_x_reg;
        anchor_y_next    = anchor_y_reg;
        press_start_next = press_start_reg;
        left_held_next   = left_held_reg;
        middle_held_next = middle_held_reg;
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;

        cmd            = '0;
        cmd.hscroll    = tgm_pkg::SCROLL_NONE;
        cmd.vscroll    = tgm_pkg::SCROLL_NONE;

        // A release of an unheld press may click and drops the buttons.
        release_tap = !sample.primary_down && prev_down_reg && !left_held_reg;
        cmd.tap     = release_tap && !supp_tap_reg;
        cmd.tap_mid = middle_held_reg;
        if (release_tap)
        begin
            left_held_next   = 1'b0;
            middle_held_next = 1'b0;
        end

        in_bounds = sample.primary_down &&
                    (sample.primary_x >= cfg.bound_left) &&
                    (sample.primary_x <= cfg.bound_right) &&
                    (sample.primary_y >= cfg.bound_top) &&
                    (sample.primary_y <= cfg.bound_bottom);

        if (!in_bounds)
        begin
            supp_tap_next   = 1'b0;
            supp_right_next = 1'b0;
        end
        else
        begin
            // Relative motion moves the wrapping cursor.
            cursor_x_next = cursor_x_reg + KB'(sample.primary_x) - KB'(prev_x_reg);
            cursor_y_next = cursor_y_reg + KB'(sample.primary_y) - KB'(prev_y_reg);

            anchor_x_next    = ax;
            anchor_y_next    = ay;
            press_start_next = press_eff;

            // Long press holds the left button.
            if (!left_held_reg && (elapsed >= TB'(cfg.hold_timeout_ms)) && !supp_tap_reg)
            begin
                left_held_next = 1'b1;
                supp_tap_next  = 1'b1;
            end

            // Travel from the anchor cancels the tap.
            moved = (xs > ax + lim_s) || (xs < ax - lim_s) ||
                    (ys > ay + lim_s) || (ys < ay - lim_s);
            if (moved)
            begin
                supp_tap_next = 1'b1;
            end

            // Lifting the second finger gives a right click.
            if (!sample.second_down && prev_second_reg && !supp_right_reg)
            begin
                supp_tap_next   = 1'b1;
                supp_right_next = 1'b1;
                left_held_next  = 1'b0;
                cmd.rclick      = 1'b1;
            end
            cmd.rclick_mid = middle_held_reg;

            // Three fingers hold the middle button.
            if (sample.second_down && sample.third_down)
            begin
                supp_tap_next    = 1'b1;
                supp_right_next  = 1'b1;
                left_held_next   = 1'b0;
                middle_held_next = 1'b1;
            end
            else
            begin
                middle_held_next = 1'b0;
            end

            // Two-finger travel steps the anchor and scrolls.
            wheel = sample.second_down &&
                    ((xs > ax + step_s) || (xs < ax - step_s) ||
                     (ys > ay + step_s) || (ys < ay - step_s));
            if (wheel)
            begin
                supp_tap_next   = 1'b1;
                supp_right_next = 1'b1;
                if (xs > ax + step_s)
                begin
                    anchor_x_next = ax + step_s;
                    cmd.hscroll   = tgm_pkg::SCROLL_RIGHT;
                end
                else if (xs < ax - step_s)
                begin
                    anchor_x_next = ax - step_s;
                    cmd.hscroll   = tgm_pkg::SCROLL_LEFT;
                end
                if (ys > ay + step_s)
                begin
                    anchor_y_next = ay + step_s;
                    cmd.vscroll   = tgm_pkg::SCROLL_DOWN;
                end
                else if (ys < ay - step_s)
                begin
                    anchor_y_next = ay - step_s;
                    cmd.vscroll   = tgm_pkg::SCROLL_UP;
                end
            end
        end

        cmd.wheel_left = left_held_next;
        cmd.wheel_mid  = middle_held_next;
        cmd.final_left = left_held_next;
        cmd.final_mid  = middle_held_next;
        cmd.cursor_x   = signed'(cursor_x_next);
        cmd.cursor_y   = signed'(cursor_y_next);
    end

    // State update on each transfer of a sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_down_reg   <= 1'b0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_second_reg <= 1'b0;
            supp_tap_reg    <= 1'b0;
            supp_right_reg  <= 1'b0;
            anchor_x_reg    <= '0;
            anchor_y_reg    <= '0;
            press_start_reg <= '0;
            left_held_reg   <= 1'b0;
            middle_held_reg <= 1'b0;
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
        end
        else if (accept)
        begin
            prev_down_reg   <= prev_down_next;
            prev_x_reg      <= prev_x_next;
            prev_y_reg      <= prev_y_next;
            prev_second_reg <= prev_second_next;
            supp_tap_reg    <= supp_tap_next;
            supp_right_reg  <= supp_right_next;
            anchor_x_reg    <= anchor_x_next;
            anchor_y_reg    <= anchor_y_next;
            press_start_reg <= press_start_next;
            left_held_reg   <= left_held_next;
            middle_held_reg <= middle_held_next;
            cursor_x_reg    <= cursor_x_next;
            cursor_y_reg    <= cursor_y_next;
        end
    end

    // A tap only happens on release, a right click only while pressed.
    a_tap_excludes_right: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !(cmd.tap && (cmd.rclick || cmd.hscroll != tgm_pkg::SCROLL_NONE)))
        else $error("tap and in-bounds events in one sample");

endmodule

// ===== sv/tgm_queue.sv =====
// Short queue of classified samples between the front and back ends.
module tgm_queue #(
    parameter int DEPTH = tgm_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tgm_pkg::tgm_cmd_t push_data,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output tgm_pkg::tgm_cmd_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    tgm_pkg::tgm_cmd_t entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]     count_reg, count_next;

    // Pointer and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full       = (count_reg == NW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    // The front end never writes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

endmodule

// ===== sv/tgm_back.sv =====
// Back end: turns each classified sample into its sequence of mouse reports.
module tgm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  tgm_pkg::tgm_cmd_t head,
    output logic              pop,
    output logic              report_valid,
    input  logic              report_stall,
    output tgm_pkg::tgm_out_t report
);

    localparam int SN = tgm_pkg::SLOT_COUNT;

    logic              report_valid_reg;
    tgm_pkg::tgm_out_t report_reg, report_next;
    logic [SN-1:0]     sent_reg, sent_next;
    logic [SN-1:0]     slots;
    logic [SN-1:0]     pend;
    logic [SN-1:0]     pick;
    logic              load;
    logic              is_final;

    // Reports this sample needs, and the first not yet sent.
    always_comb
    begin
        slots = '0;
        slots[tgm_pkg::SLOT_TAP]    = head.tap;
        slots[tgm_pkg::SLOT_RIGHT]  = head.rclick;
        slots[tgm_pkg::SLOT_HWHEEL] = (head.hscroll != tgm_pkg::SCROLL_NONE);
        slots[tgm_pkg::SLOT_VWHEEL] = (head.vscroll != tgm_pkg::SCROLL_NONE);
        slots[tgm_pkg::SLOT_FINAL]  = 1'b1;
        pend     = slots & ~sent_reg;
        pick     = pend & (~pend + 1'b1);
        is_final = pick[tgm_pkg::SLOT_FINAL];
    end

    // Build the picked report.
    always_comb
    begin
        report_next               = '0;
        report_next.cursor_x      = head.cursor_x;
        report_next.cursor_y      = head.cursor_y;
        report_next.scroll_event  = tgm_pkg::SCROLL_NONE;
        if (pick[tgm_pkg::SLOT_TAP])
        begin
            report_next.left_button   = 1'b1;
            report_next.middle_button = head.tap_mid;
        end
        else if (pick[tgm_pkg::SLOT_RIGHT])
        begin
            report_next.right_button  = 1'b1;
            report_next.middle_button = head.rclick_mid;
        end
        else if (pick[tgm_pkg::SLOT_HWHEEL])
        begin
            report_next.left_button   = head.wheel_left;
            report_next.middle_button = head.wheel_mid;
            report_next.scroll_event  = head.hscroll;
        end
        else if (pick[tgm_pkg::SLOT_VWHEEL])
        begin
            report_next.left_button   = head.wheel_left;
            report_next.middle_button = head.wheel_mid;
            report_next.scroll_event  = head.vscroll;
        end
        else
        begin
            report_next.left_button   = head.final_left;
            report_next.middle_button = head.final_mid;
            report_next.last_report   = 1'b1;
        end
    end

    // Load the output register when it is empty or its transfer completes.
    assign load = head_valid && (!report_valid_reg || !report_stall);
    assign pop  = load && is_final;

    always_comb
    begin
        sent_next = sent_reg;
        if (load)
        begin
            sent_next = is_final ? '0 : (sent_reg | pick);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_valid_reg <= 1'b0;
            sent_reg         <= '0;
        end
        else
        begin
            sent_reg <= sent_next;
            if (load)
            begin
                report_valid_reg <= 1'b1;
            end
            else if (!report_stall)
            begin
                report_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            report_reg <= report_next;
        end
    end

    assign report_valid = report_valid_reg;
    assign report       = report_reg;

    // The final report of a sample carries no click or scroll.
    a_final_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (report_valid && report.last_report) |->
            (report.scroll_event == tgm_pkg::SCROLL_NONE && !report.right_button))
        else $error("final report carries an event");

    // Progress through a sample is only kept while that sample is at the head.
    a_sent_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        (sent_reg != '0) |-> head_valid)
        else $error("sent mask without a queued sample");

    // Popping a sample starts the next one from its first report.
    a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (sent_reg == '0))
        else $error("sent mask not cleared after pop");

endmodule

// ===== sv/touchpad_gesture_to_mouse_core.sv =====
// Top level of the touchpad gesture to mouse core: configuration registers and wiring.
//
// Usage: touch samples enter on the sample channel (sample_valid / sample_stall /
// sample); mouse reports leave on the report channel (report_valid / report_stall /
// report). A transfer happens on a rising edge with valid high and stall low.
// Each sample gives one to four reports: optional tap click, right click,
// horizontal and vertical wheel reports in that order, then one state report
// with last_report set.
// The front end classifies a sample in the cycle of its transfer and writes it
// into a two-entry queue; while the receiver does not stall, the back end sends
// one report per cycle from a single output register. The first report of a
// sample passes through the queue entry and then the output register; a sample
// that gives k reports holds the back end until all k are sent, so with an idle
// receiver a new sample can be taken every cycle when each gives a single report.
// When the receiver stalls, the report is held and the queue fills; sample_stall rises
// once the queue is full. Reset clears the gesture state, the queue and the output,
// and loads the configuration defaults. Configuration writes (cfg_we, cfg_index,
// cfg_data) take effect at the edge; the user must write while idle (not enforced).
module touchpad_gesture_to_mouse_core #(
    parameter int QUEUE_DEPTH = tgm_pkg::QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  tgm_pkg::tgm_in_t                   sample,
    output logic                               report_valid,
    input  logic                               report_stall,
    output tgm_pkg::tgm_out_t                  report,
    input  logic                               cfg_we,
    input  logic [tgm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tgm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int CB = tgm_pkg::COORD_BITS;

    tgm_pkg::tgm_cfg_t cfg_reg;
    tgm_pkg::tgm_cmd_t cmd;
    tgm_pkg::tgm_cmd_t head;
    logic              accept;
    logic              full;
    logic              head_valid;
    logic              pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bound_left      <= tgm_pkg::RST_BOUND_LEFT;
            cfg_reg.bound_top       <= tgm_pkg::RST_BOUND_TOP;
            cfg_reg.bound_right     <= tgm_pkg::RST_BOUND_RIGHT;
            cfg_reg.bound_bottom    <= tgm_pkg::RST_BOUND_BOTTOM;
            cfg_reg.hold_timeout_ms <= tgm_pkg::RST_HOLD_TIMEOUT;
            cfg_reg.tap_move_limit  <= tgm_pkg::RST_TAP_LIMIT;
            cfg_reg.wheel_step      <= tgm_pkg::RST_WHEEL_STEP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tgm_pkg::CFG_BOUND_LEFT:   cfg_reg.bound_left      <= cfg_data[CB-1:0];
                tgm_pkg::CFG_BOUND_TOP:    cfg_reg.bound_top       <= cfg_data[CB-1:0];
                tgm_pkg::CFG_BOUND_RIGHT:  cfg_reg.bound_right     <= cfg_data[CB-1:0];
                tgm_pkg::CFG_BOUND_BOTTOM: cfg_reg.bound_bottom    <= cfg_data[CB-1:0];
                tgm_pkg::CFG_HOLD_TIMEOUT: cfg_reg.hold_timeout_ms <= cfg_data;
                tgm_pkg::CFG_TAP_LIMIT:    cfg_reg.tap_move_limit  <= cfg_data[CB-1:0];
                tgm_pkg::CFG_WHEEL_STEP:   cfg_reg.wheel_step      <= cfg_data[CB-1:0];
                default:                   cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Sample transfer is taken whenever the queue has room.
    assign sample_stall = full;
    assign accept       = sample_valid && !full;

    tgm_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .sample (sample),
        .accept (accept),
        .cmd    (cmd)
    );

    tgm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (cmd),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    tgm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report)
    );

endmodule
